@@ design/gpio_pkg.sv @@
// Shared constants, types and mask functions of the GPIO register block.
package gpio_pkg;

	// Number of pins that exist; pins at or above this count are not stored.
	localparam int PIN_COUNT = 58;

	// Fixed widths, word counts and pins per word.
	localparam int PAD_W   = 58;
	localparam int DATA_W  = 32;
	localparam int OFS_W   = 6;
	localparam int FSEL_W  = 30;
	localparam int CODE_W  = 3;
	localparam int FSEL_WORDS = 6;
	localparam int PULL_WORDS = 4;
	localparam int PINS_PER_FSEL = 10;
	localparam int PINS_PER_PULL = 16;
	localparam int FSEL_PIN_LIMIT = FSEL_WORDS * PINS_PER_FSEL;

	// Access kinds.
	typedef enum logic [1:0] {
		FUNC_IDLE  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Function code that turns a pin into an output.
	localparam logic [CODE_W-1:0] CODE_OUTPUT = 3'd1;

	// Register word offsets.
	localparam logic [OFS_W-1:0] OFS_FSEL_LAST = 6'd5;
	localparam logic [OFS_W-1:0] OFS_SET0  = 6'd7;
	localparam logic [OFS_W-1:0] OFS_SET1  = 6'd8;
	localparam logic [OFS_W-1:0] OFS_CLR0  = 6'd10;
	localparam logic [OFS_W-1:0] OFS_CLR1  = 6'd11;
	localparam logic [OFS_W-1:0] OFS_LEV0  = 6'd13;
	localparam logic [OFS_W-1:0] OFS_LEV1  = 6'd14;
	localparam logic [OFS_W-1:0] OFS_PULL0 = 6'd57;
	localparam logic [OFS_W-1:0] OFS_PULL3 = 6'd60;

	typedef logic [FSEL_W-1:0] fsel_word_t;
	typedef logic [DATA_W-1:0] data_word_t;
	typedef logic [PAD_W-1:0]  pin_vec_t;

	// Bits of the pin vector that belong to existing pins.
	function automatic pin_vec_t pin_mask();
		pin_vec_t m;
		m = '0;
		for (int p = 0; p < PAD_W; p++) begin
			if (p < PIN_COUNT)
				m[p] = 1'b1;
		end
		return m;
	endfunction

	localparam pin_vec_t PIN_MASK = pin_mask();

	// Stored bits of one function-select word: three bits per existing pin.
	function automatic fsel_word_t fsel_mask(input logic [2:0] w);
		fsel_word_t m;
		m = '0;
		for (int k = 0; k < PINS_PER_FSEL; k++) begin
			if (int'(w) * PINS_PER_FSEL + k < PIN_COUNT)
				m[CODE_W*k +: CODE_W] = '1;
		end
		return m;
	endfunction

	// Stored bits of one pull-mode word: two bits per existing pin.
	function automatic data_word_t pull_mask(input logic [1:0] w);
		data_word_t m;
		m = '0;
		for (int k = 0; k < PINS_PER_PULL; k++) begin
			if (int'(w) * PINS_PER_PULL + k < PIN_COUNT)
				m[2*k +: 2] = 2'b11;
		end
		return m;
	endfunction

endpackage

@@ design/gpio_register_block.sv @@
// Top level of the GPIO register block: input register, register file and result register.
// Each accepted item is one bus access (idle sample, read or write) and yields exactly one
// result: the item lands in an input register, the register file is read and updated when
// the item moves into the result register, and the result register holds read data, the error
// flag, the output latch and the output enables as they stand after that access. A new item
// is taken every cycle while results are taken; the result register and the input register
// let one item wait on each side, so in_stall rises only when both are full and out_stall is
// high. Level reads return the pad levels carried with the same item. Offsets outside the map
// read zero, ignore writes and flag access_error.
module gpio_register_block (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [5:0]  word_offset,
	input  logic [31:0] write_data,
	input  logic [57:0] pad_levels,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        access_error,
	output logic [57:0] drive_levels,
	output logic [57:0] drive_enables
);

	// Input register.
	logic                                  valid_s1;
	logic [1:0]                            func_s1;
	logic [gpio_pkg::OFS_W-1:0]            ofs_s1;
	gpio_pkg::data_word_t                  data_s1;
	gpio_pkg::pin_vec_t                    pads_s1;

	// Register file.
	gpio_pkg::fsel_word_t                  fsel_q [gpio_pkg::FSEL_WORDS];
	gpio_pkg::data_word_t                  pull_q [gpio_pkg::PULL_WORDS];
	gpio_pkg::pin_vec_t                    latch_q;

	// Result register.
	logic                                  out_valid_q;
	gpio_pkg::data_word_t                  rd_q;
	logic                                  err_q;
	gpio_pkg::pin_vec_t                    levels_q;
	gpio_pkg::pin_vec_t                    enables_q;

	// Access decode and next-state values.
	logic                                  advance;
	logic                                  is_read;
	logic                                  is_write;
	logic                                  hit_fsel;
	logic                                  hit_setclr;
	logic                                  hit_lev0;
	logic                                  hit_lev1;
	logic                                  hit_pull;
	logic [2:0]                            fsel_idx;
	logic [1:0]                            pull_idx;
	logic [63:0]                           pads_ext;
	logic [63:0]                           data_hi;
	gpio_pkg::data_word_t                  rd_next;
	logic                                  err_next;
	gpio_pkg::pin_vec_t                    latch_next;
	gpio_pkg::fsel_word_t                  fsel_next [gpio_pkg::FSEL_WORDS];
	gpio_pkg::pin_vec_t                    enables_next;

	// Handshake: the input register moves on when the result register is free or being taken.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;

	assign read_data     = rd_q;
	assign access_error  = err_q;
	assign drive_levels  = levels_q;
	assign drive_enables = enables_q;

	// Offset decode of the item in the input register.
	always_comb begin
		is_read    = (func_s1 == gpio_pkg::FUNC_READ);
		is_write   = (func_s1 == gpio_pkg::FUNC_WRITE);
		hit_fsel   = (ofs_s1 <= gpio_pkg::OFS_FSEL_LAST);
		hit_setclr = (ofs_s1 == gpio_pkg::OFS_SET0) || (ofs_s1 == gpio_pkg::OFS_SET1) ||
			(ofs_s1 == gpio_pkg::OFS_CLR0) || (ofs_s1 == gpio_pkg::OFS_CLR1);
		hit_lev0   = (ofs_s1 == gpio_pkg::OFS_LEV0);
		hit_lev1   = (ofs_s1 == gpio_pkg::OFS_LEV1);
		hit_pull   = (ofs_s1 >= gpio_pkg::OFS_PULL0) && (ofs_s1 <= gpio_pkg::OFS_PULL3);
		fsel_idx   = ofs_s1[2:0];
		pull_idx   = ofs_s1[1:0] - gpio_pkg::OFS_PULL0[1:0];
		pads_ext   = {{(64 - gpio_pkg::PAD_W){1'b0}}, pads_s1 & gpio_pkg::PIN_MASK};
		data_hi    = {data_s1, 32'd0};
	end

	// Read data and error flag.
	always_comb begin
		rd_next  = '0;
		err_next = 1'b0;
		if (is_read) begin
			priority if (hit_fsel)
				rd_next = {2'b00, fsel_q[fsel_idx]};
			else if (hit_setclr)
				rd_next = '0;
			else if (hit_lev0)
				rd_next = pads_ext[31:0];
			else if (hit_lev1)
				rd_next = pads_ext[63:32];
			else if (hit_pull)
				rd_next = pull_q[pull_idx];
			else
				err_next = 1'b1;
		end else if (is_write) begin
			err_next = !(hit_fsel || hit_setclr || hit_lev0 || hit_lev1 || hit_pull);
		end
	end

	// Output latch after this access: set and clear words touch only existing pins.
	always_comb begin
		latch_next = latch_q;
		if (is_write) begin
			unique case (1'b1)
				(ofs_s1 == gpio_pkg::OFS_SET0):
					latch_next = latch_q | {{(gpio_pkg::PAD_W - 32){1'b0}}, data_s1};
				(ofs_s1 == gpio_pkg::OFS_SET1):
					latch_next = latch_q | data_hi[gpio_pkg::PAD_W-1:0];
				(ofs_s1 == gpio_pkg::OFS_CLR0):
					latch_next = latch_q & ~{{(gpio_pkg::PAD_W - 32){1'b0}}, data_s1};
				(ofs_s1 == gpio_pkg::OFS_CLR1):
					latch_next = latch_q & ~data_hi[gpio_pkg::PAD_W-1:0];
				default:
					latch_next = latch_q;
			endcase
			latch_next = latch_next & gpio_pkg::PIN_MASK;
		end
	end

	// Function words after this access, and the output enables they give.
	always_comb begin
		for (int w = 0; w < gpio_pkg::FSEL_WORDS; w++) begin
			fsel_next[w] = fsel_q[w];
		end
		if (is_write && hit_fsel)
			fsel_next[fsel_idx] = data_s1[gpio_pkg::FSEL_W-1:0] & gpio_pkg::fsel_mask(fsel_idx);
		enables_next = '0;
		for (int p = 0; p < gpio_pkg::PAD_W; p++) begin
			if (p < gpio_pkg::FSEL_PIN_LIMIT && p < gpio_pkg::PIN_COUNT)
				enables_next[p] = (fsel_next[p / gpio_pkg::PINS_PER_FSEL]
					[gpio_pkg::CODE_W * (p % gpio_pkg::PINS_PER_FSEL) +: gpio_pkg::CODE_W]
					== gpio_pkg::CODE_OUTPUT);
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			ofs_s1  <= word_offset;
			data_s1 <= write_data;
			pads_s1 <= pad_levels;
		end
	end

	// Register file update, done when the item moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < gpio_pkg::FSEL_WORDS; w++) begin
				fsel_q[w] <= '0;
			end
			for (int w = 0; w < gpio_pkg::PULL_WORDS; w++) begin
				pull_q[w] <= '0;
			end
			latch_q <= '0;
		end else if (advance) begin
			for (int w = 0; w < gpio_pkg::FSEL_WORDS; w++) begin
				fsel_q[w] <= fsel_next[w];
			end
			if (is_write && hit_pull)
				pull_q[pull_idx] <= data_s1 & gpio_pkg::pull_mask(pull_idx);
			latch_q <= latch_next;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q      <= rd_next;
			err_q     <= err_next;
			levels_q  <= latch_next;
			enables_q <= enables_next;
		end
	end

	// The shown output levels always match the latch, since both load together.
	a_levels_track_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (levels_q == latch_q))
		else $error("drive_levels differs from the output latch");

	// A held result keeps the register file frozen.
	a_state_frozen_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(latch_q) && $stable(enables_q)))
		else $error("register state changed while the result was stalled");

	// An unmapped access never returns data.
	a_error_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> (rd_q == '0))
		else $error("error result carries nonzero read data");

	// Back-pressure to the source only when the input register holds an item.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a waiting item");

endmodule

@@ tb/sv/tb_gpio_register_block.sv @@
// Testbench for the GPIO register block: directed and random accesses against a predictor.
`timescale 1ns / 100ps

module tb_gpio_register_block;

	typedef logic [gpio_pkg::OFS_W-1:0]  ofs_t;
	typedef logic [gpio_pkg::CODE_W-1:0] code_t;

	// Function-select words addressed by the directed checks.
	localparam ofs_t OFS_FSEL0 = 6'd0;
	localparam ofs_t OFS_FSEL1 = 6'd1;

	// Offsets outside the register map, used by the directed checks.
	localparam ofs_t OFS_GAP_LOW     = 6'd6;
	localparam ofs_t OFS_BEFORE_PULL = 6'd56;
	localparam ofs_t OFS_AFTER_PULL  = 6'd61;
	localparam ofs_t OFS_TOP         = 6'd63;

	// Function word with the output code in every slot.
	localparam gpio_pkg::data_word_t ALL_OUTPUT_CODES = 32'h0924_9249;

	localparam ofs_t LATCH_OFS [4] = '{gpio_pkg::OFS_SET0, gpio_pkg::OFS_SET1,
		gpio_pkg::OFS_CLR0, gpio_pkg::OFS_CLR1};

	typedef struct packed {
		gpio_pkg::data_word_t read_data;
		logic                 access_error;
		gpio_pkg::pin_vec_t   drive_levels;
		gpio_pkg::pin_vec_t   drive_enables;
	} access_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            func = gpio_pkg::FUNC_IDLE;
	ofs_t                  word_offset = '0;
	gpio_pkg::data_word_t  write_data = '0;
	gpio_pkg::pin_vec_t    pad_levels = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	gpio_pkg::data_word_t  read_data;
	logic                  access_error;
	gpio_pkg::pin_vec_t    drive_levels;
	gpio_pkg::pin_vec_t    drive_enables;

	// Predicted register state.
	gpio_pkg::fsel_word_t fsel_state [gpio_pkg::FSEL_WORDS];
	gpio_pkg::data_word_t pull_state [gpio_pkg::PULL_WORDS];
	gpio_pkg::pin_vec_t   latch_state;

	access_result_t pending_results [$];
	int unsigned    failures = 0;
	int unsigned    sender_idle_pct = 0;
	int unsigned    stall_pct = 0;
	int unsigned    hold_request = 0;

	gpio_register_block dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.word_offset  (word_offset),
		.write_data   (write_data),
		.pad_levels   (pad_levels),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.access_error (access_error),
		.drive_levels (drive_levels),
		.drive_enables(drive_enables)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one access to the predicted state and queue the result it should produce.
	function automatic void predict_access(input gpio_pkg::func_t kind, input ofs_t ofs,
			input gpio_pkg::data_word_t data, input gpio_pkg::pin_vec_t pads);
		access_result_t       res;
		gpio_pkg::pin_vec_t   live;
		gpio_pkg::fsel_word_t keep3;
		gpio_pkg::data_word_t keep2;
		code_t                pin_code;
		int                   w;
		res = '0;
		live = '0;
		for (int p = 0; p < gpio_pkg::PAD_W; p++) begin
			if (p < gpio_pkg::PIN_COUNT)
				live[p] = 1'b1;
		end
		if (kind == gpio_pkg::FUNC_READ) begin
			if (ofs <= gpio_pkg::OFS_FSEL_LAST)
				res.read_data = gpio_pkg::data_word_t'(fsel_state[ofs]);
			else if (ofs == gpio_pkg::OFS_SET0 || ofs == gpio_pkg::OFS_SET1 ||
					ofs == gpio_pkg::OFS_CLR0 || ofs == gpio_pkg::OFS_CLR1)
				res.read_data = '0;
			else if (ofs == gpio_pkg::OFS_LEV0)
				res.read_data = gpio_pkg::data_word_t'(pads & live);
			else if (ofs == gpio_pkg::OFS_LEV1)
				res.read_data = gpio_pkg::data_word_t'((pads & live) >> 32);
			else if (ofs >= gpio_pkg::OFS_PULL0 && ofs <= gpio_pkg::OFS_PULL3)
				res.read_data = pull_state[ofs - gpio_pkg::OFS_PULL0];
			else
				res.access_error = 1'b1;
		end else if (kind == gpio_pkg::FUNC_WRITE) begin
			if (ofs <= gpio_pkg::OFS_FSEL_LAST) begin
				keep3 = '0;
				w = int'(ofs);
				for (int k = 0; k < gpio_pkg::PINS_PER_FSEL; k++) begin
					if (w * gpio_pkg::PINS_PER_FSEL + k < gpio_pkg::PIN_COUNT)
						keep3[gpio_pkg::CODE_W*k +: gpio_pkg::CODE_W] = '1;
				end
				fsel_state[ofs] = data[gpio_pkg::FSEL_W-1:0] & keep3;
			end else if (ofs == gpio_pkg::OFS_SET0) begin
				latch_state = latch_state | gpio_pkg::pin_vec_t'(data);
			end else if (ofs == gpio_pkg::OFS_SET1) begin
				latch_state = latch_state | (gpio_pkg::pin_vec_t'(data) << 32);
			end else if (ofs == gpio_pkg::OFS_CLR0) begin
				latch_state = latch_state & ~gpio_pkg::pin_vec_t'(data);
			end else if (ofs == gpio_pkg::OFS_CLR1) begin
				latch_state = latch_state & ~(gpio_pkg::pin_vec_t'(data) << 32);
			end else if (ofs == gpio_pkg::OFS_LEV0 || ofs == gpio_pkg::OFS_LEV1) begin
				// Level words are read only; the write is dropped without error.
			end else if (ofs >= gpio_pkg::OFS_PULL0 && ofs <= gpio_pkg::OFS_PULL3) begin
				keep2 = '0;
				w = int'(ofs - gpio_pkg::OFS_PULL0);
				for (int k = 0; k < gpio_pkg::PINS_PER_PULL; k++) begin
					if (w * gpio_pkg::PINS_PER_PULL + k < gpio_pkg::PIN_COUNT)
						keep2[2*k +: 2] = 2'b11;
				end
				pull_state[w] = data & keep2;
			end else begin
				res.access_error = 1'b1;
			end
			latch_state = latch_state & live;
		end
		res.drive_levels = latch_state;
		for (int p = 0; p < gpio_pkg::PAD_W; p++) begin
			if (p < gpio_pkg::PIN_COUNT && p < gpio_pkg::FSEL_PIN_LIMIT) begin
				pin_code = fsel_state[p / gpio_pkg::PINS_PER_FSEL]
					[gpio_pkg::CODE_W*(p % gpio_pkg::PINS_PER_FSEL) +: gpio_pkg::CODE_W];
				if (pin_code == gpio_pkg::CODE_OUTPUT)
					res.drive_enables[p] = 1'b1;
			end
		end
		pending_results.push_back(res);
	endfunction

	// Offer one item, idling first at random, and record its prediction once it is taken.
	task automatic send_access(input gpio_pkg::func_t kind, input ofs_t ofs,
			input gpio_pkg::data_word_t data, input gpio_pkg::pin_vec_t pads);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		func        <= kind;
		word_offset <= ofs;
		write_data  <= data;
		pad_levels  <= pads;
		do
			@(posedge clk);
		while (in_stall);
		predict_access(kind, ofs, data, pads);
	endtask

	// Receiver: random stall, or a long hold-off when one is requested.
	always begin : receiver
		int unsigned span;
		@(negedge clk);
		if (hold_request != 0) begin
			span = hold_request;
			hold_request = 0;
			out_stall <= 1'b1;
			repeat (span) @(negedge clk);
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin : result_check
		access_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no access outstanding");
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, read_data);
					failures++;
				end
				if (access_error !== want.access_error) begin
					$error("access_error: expected %b, got %b", want.access_error, access_error);
					failures++;
				end
				if (drive_levels !== want.drive_levels) begin
					$error("drive_levels: expected %h, got %h", want.drive_levels, drive_levels);
					failures++;
				end
				if (drive_enables !== want.drive_enables) begin
					$error("drive_enables: expected %h, got %h", want.drive_enables,
						drive_enables);
					failures++;
				end
			end
		end
	end

	// Function words: unstored top bits, the partly used last word and output enables.
	task automatic test_function_select();
		send_access(gpio_pkg::FUNC_WRITE, OFS_FSEL0, '1, '0);
		send_access(gpio_pkg::FUNC_READ, OFS_FSEL0, '0, '0);
		send_access(gpio_pkg::FUNC_WRITE, gpio_pkg::OFS_FSEL_LAST, '1, '0);
		send_access(gpio_pkg::FUNC_READ, gpio_pkg::OFS_FSEL_LAST, '0, '0);
		send_access(gpio_pkg::FUNC_WRITE, OFS_FSEL1, ALL_OUTPUT_CODES, '0);
		send_access(gpio_pkg::FUNC_WRITE, gpio_pkg::OFS_FSEL_LAST, ALL_OUTPUT_CODES, '0);
		send_access(gpio_pkg::FUNC_WRITE, OFS_FSEL0, '0, '0);
	endtask

	// Set and clear words, including bits of pins that do not exist.
	task automatic test_output_latch();
		send_access(gpio_pkg::FUNC_WRITE, gpio_pkg::OFS_SET0, '1, '0);
		send_access(gpio_pkg::FUNC_WRITE, gpio_pkg::OFS_SET1, '1, '0);
		send_access(gpio_pkg::FUNC_READ, gpio_pkg::OFS_SET0, '0, '0);
		send_access(gpio_pkg::FUNC_READ, gpio_pkg::OFS_CLR1, '0, '0);
		send_access(gpio_pkg::FUNC_WRITE, gpio_pkg::OFS_CLR0, 32'h0000_FFFF, '0);
		send_access(gpio_pkg::FUNC_WRITE, gpio_pkg::OFS_CLR1, '1, '0);
	endtask

	// Level words follow the pads of the same item and ignore writes.
	task automatic test_pad_levels();
		send_access(gpio_pkg::FUNC_READ, gpio_pkg::OFS_LEV0, '0, '1);
		send_access(gpio_pkg::FUNC_READ, gpio_pkg::OFS_LEV1, '0, '1);
		send_access(gpio_pkg::FUNC_READ, gpio_pkg::OFS_LEV1, '0, {29{2'b10}});
		send_access(gpio_pkg::FUNC_WRITE, gpio_pkg::OFS_LEV0, '1, '1);
	endtask

	// Pull words, with the last one only partly stored.
	task automatic test_pull_modes();
		send_access(gpio_pkg::FUNC_WRITE, gpio_pkg::OFS_PULL3, '1, '0);
		send_access(gpio_pkg::FUNC_READ, gpio_pkg::OFS_PULL3, '0, '0);
		send_access(gpio_pkg::FUNC_WRITE, gpio_pkg::OFS_PULL0, 32'hAAAA_AAAA, '0);
		send_access(gpio_pkg::FUNC_READ, gpio_pkg::OFS_PULL0, '0, '0);
	endtask

	// Unmapped offsets flag an error; idle and the unused kind never do.
	task automatic test_unmapped_and_idle();
		send_access(gpio_pkg::FUNC_READ, OFS_GAP_LOW, '0, '0);
		send_access(gpio_pkg::FUNC_WRITE, OFS_TOP, '1, '0);
		send_access(gpio_pkg::FUNC_READ, OFS_BEFORE_PULL, '0, '0);
		send_access(gpio_pkg::FUNC_READ, OFS_AFTER_PULL, '0, '0);
		send_access(gpio_pkg::FUNC_IDLE, OFS_TOP, '1, '1);
		send_access(gpio_pkg::FUNC_NONE, OFS_GAP_LOW, '1, '1);
	endtask

	// Random accesses weighted toward mapped registers and output codes.
	task automatic test_random_accesses(input int unsigned count);
		gpio_pkg::func_t       kind;
		ofs_t                  ofs;
		gpio_pkg::data_word_t  data;
		logic [63:0]           pads;
		int unsigned           pick;
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			kind = (pick < 40) ? gpio_pkg::FUNC_WRITE : (pick < 75) ? gpio_pkg::FUNC_READ :
				(pick < 88) ? gpio_pkg::FUNC_IDLE : gpio_pkg::FUNC_NONE;
			pick = $urandom_range(99);
			if (pick < 15)
				ofs = ofs_t'($urandom_range(63));
			else if (pick < 45)
				ofs = ofs_t'($urandom_range(gpio_pkg::OFS_FSEL_LAST));
			else if (pick < 70)
				ofs = LATCH_OFS[$urandom_range(3)];
			else if (pick < 80)
				ofs = $urandom_range(1) ? gpio_pkg::OFS_LEV1 : gpio_pkg::OFS_LEV0;
			else
				ofs = ofs_t'($urandom_range(gpio_pkg::OFS_PULL3, gpio_pkg::OFS_PULL0));
			data = $urandom;
			// Half the function writes put many pins into output mode.
			if (ofs <= gpio_pkg::OFS_FSEL_LAST && $urandom_range(1)) begin
				for (int k = 0; k < gpio_pkg::PINS_PER_FSEL; k++) begin
					case ($urandom_range(3))
						0: data[gpio_pkg::CODE_W*k +: gpio_pkg::CODE_W] = '0;
						1, 2: data[gpio_pkg::CODE_W*k +: gpio_pkg::CODE_W] =
							gpio_pkg::CODE_OUTPUT;
						default: data[gpio_pkg::CODE_W*k +: gpio_pkg::CODE_W] =
							code_t'($urandom);
					endcase
				end
			end
			pads = {$urandom, $urandom};
			case ($urandom_range(15))
				0: pads = '0;
				1: pads = '1;
				default: ;
			endcase
			send_access(kind, ofs, data, pads[gpio_pkg::PAD_W-1:0]);
		end
	endtask

	// Long receiver hold-off while the sender keeps offering items.
	task automatic test_backpressure();
		int unsigned saved_idle;
		saved_idle = sender_idle_pct;
		sender_idle_pct = 0;
		hold_request = 64;
		test_random_accesses(30);
		sender_idle_pct = saved_idle;
	endtask

	// Main sequence.
	initial begin
		for (int i = 0; i < gpio_pkg::FSEL_WORDS; i++)
			fsel_state[i] = '0;
		for (int i = 0; i < gpio_pkg::PULL_WORDS; i++)
			pull_state[i] = '0;
		latch_state = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_function_select();
		test_output_latch();
		test_pad_levels();
		test_pull_modes();
		test_unmapped_and_idle();

		sender_idle_pct = 20;
		stall_pct = 65;
		test_random_accesses(530);

		sender_idle_pct = 65;
		stall_pct = 20;
		test_random_accesses(530);
		test_backpressure();

		sender_idle_pct = 0;
		stall_pct = 0;
		test_random_accesses(530);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("tb_gpio_register_block: PASS");
		else
			$display("tb_gpio_register_block: FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#4000000;
		$display("tb_gpio_register_block: FAIL");
		$finish;
	end

endmodule
